>>> rtl/signed_multiply_divide_unit_macros.svh
// Assertion macros shared by the unit's modules.
`ifndef SIGNED_MULTIPLY_DIVIDE_UNIT_MACROS_SVH
`define SIGNED_MULTIPLY_DIVIDE_UNIT_MACROS_SVH

// Implication that holds in the same cycle.
`define SMDU_ASSERT_IMPL(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error(msg);

// Implication checked in the following cycle.
`define SMDU_ASSERT_NEXT(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error(msg);

`endif

>>> rtl/smdu_pkg.sv
package smdu_pkg;

    // Operation codes.
    localparam logic [1:0] OP_DIV  = 2'd0;
    localparam logic [1:0] OP_MULW = 2'd1;
    localparam logic [1:0] OP_MULT = 2'd2;

    // Size codes.
    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;

    localparam int DATA_W = 32;
    localparam int IN_TDATA_W = 104;
    localparam int OUT_TDATA_W = 72;
    localparam int QUEUE_DEPTH = 4;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  sz;
        logic        a_neg;
        logic        b_neg;
        logic [63:0] a_mag;
        logic [31:0] b_mag;
        logic [31:0] lo;
        logic [31:0] hi;
    } smdu_item_t;

    // Result item.
    typedef struct packed {
        logic        div_err;
        logic        cf;
        logic [31:0] r_hi;
        logic [31:0] r_lo;
    } smdu_res_t;

    // Sign-extends the low bits of a value per size.
    function automatic logic [31:0] sext32(input logic [31:0] v, input logic [1:0] sz);
        logic [31:0] r;
        case (sz)
            SZ_8:    r = {{24{v[7]}}, v[7:0]};
            SZ_16:   r = {{16{v[15]}}, v[15:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/smdu_front.sv
// Front end: decodes size, forms operand magnitudes and signs.
module smdu_front
    import smdu_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [IN_TDATA_W-1:0]   in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output smdu_item_t              out_item
);
    logic [1:0]  op, sz;
    logic [31:0] lo, hi, src, se_src, se_lo, b_mag;
    logic [63:0] dvd, a_mag;
    logic        a_neg, b_neg;
    logic        valid_reg;
    smdu_item_t  item_reg, item_next;

    assign op  = in_data[1:0];
    assign sz  = in_data[3:2];
    assign lo  = in_data[35:4];
    assign hi  = in_data[67:36];
    assign src = in_data[99:68];

    // Dividend and divisor (or multiplicands) sign-extended to full width.
    always_comb begin
        se_src = sext32(src, sz);
        se_lo  = sext32(lo, sz);
        case (sz)
            SZ_8:    dvd = {{48{hi[7]}}, hi[7:0], lo[7:0]};
            SZ_16:   dvd = {{32{hi[15]}}, hi[15:0], lo[15:0]};
            default: dvd = {hi, lo};
        endcase
        if (op == OP_DIV) begin
            a_neg = dvd[63];
            a_mag = a_neg ? (~dvd + 64'd1) : dvd;
        end else begin
            a_neg = se_lo[31];
            a_mag = {32'd0, a_neg ? (~se_lo + 32'd1) : se_lo};
        end
        b_neg = se_src[31];
        b_mag = b_neg ? (~se_src + 32'd1) : se_src;
        item_next = '{op: op, sz: sz, a_neg: a_neg, b_neg: b_neg, a_mag: a_mag,
                      b_mag: b_mag, lo: lo, hi: hi};
    end

    assign in_ready = !valid_reg || out_ready;

    // Output register of the front end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
endmodule

>>> rtl/smdu_queue.sv
// Short queue between front and back ends.
module smdu_queue
    import smdu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  smdu_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output smdu_item_t out_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    smdu_item_t mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = cnt_reg != (AW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;
    assign out_item = mem[rd_reg];

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= in_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

`include "signed_multiply_divide_unit_macros.svh"
    `SMDU_ASSERT_IMPL(a_no_overfill, aclk, aresetn, 1'b1, cnt_reg <= (AW+1)'(DEPTH), "queue overfilled")
    `SMDU_ASSERT_NEXT(a_push_only, aclk, aresetn, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "count did not rise")
    `SMDU_ASSERT_NEXT(a_pop_only, aclk, aresetn, pop && !push, cnt_reg == $past(cnt_reg) - 1'b1, "count did not fall")
endmodule

>>> rtl/smdu_back.sv
// Back end: pipelined magnitude multiply and a pipelined restoring divider.
// Stage 0 takes the item, stages 1..64 each retire one quotient bit, then
// one stage applies signs and range checks. The 32x32 product is formed in
// stage 0 and carried along.
module smdu_back
    import smdu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  smdu_item_t  in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output smdu_res_t   out_res
);
    localparam int NS = 64;

    typedef struct packed {
        smdu_item_t  it;
        logic [63:0] prod;
        logic [63:0] rem;
        logic [63:0] quo;
    } stage_t;

    stage_t      st_reg [NS+1];
    logic [NS:0] v_reg;
    logic        adv;
    logic        rvalid_reg;
    smdu_res_t   res_reg, res_next;

    // The whole pipeline moves when the result register can take an item.
    assign adv = !rvalid_reg || out_ready;
    assign in_ready = adv;

    // Stage 0: magnitude product.
    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0].it   <= in_item;
            st_reg[0].prod <= in_item.a_mag[31:0] * in_item.b_mag;
            st_reg[0].rem  <= '0;
            st_reg[0].quo  <= in_item.a_mag;
        end
    end

    // One restoring divide step per stage.
    for (genvar g = 1; g <= NS; g++) begin : g_div
        logic [64:0] trial;
        logic [63:0] shr;
        assign shr   = {st_reg[g-1].rem[62:0], st_reg[g-1].quo[63]};
        assign trial = {1'b0, shr} - {33'd0, st_reg[g-1].it.b_mag};
        always_ff @(posedge aclk) begin
            if (adv) begin
                st_reg[g].it   <= st_reg[g-1].it;
                st_reg[g].prod <= st_reg[g-1].prod;
                st_reg[g].rem  <= trial[64] ? shr : trial[63:0];
                st_reg[g].quo  <= {st_reg[g-1].quo[62:0], ~trial[64]};
            end
        end
    end

    // Final stage: signs, range checks and flags.
    always_comb begin
        smdu_item_t  it;
        logic [63:0] q, r, p, sp, qs, rs;
        logic [31:0] m, lim, pl;
        logic        qneg, ovf;
        it = st_reg[NS].it;
        q  = st_reg[NS].quo;
        r  = st_reg[NS].rem;
        p  = st_reg[NS].prod;
        qneg = it.a_neg ^ it.b_neg;
        case (it.sz)
            SZ_8:    begin m = 32'h0000_00ff; lim = 32'h0000_0080; end
            SZ_16:   begin m = 32'h0000_ffff; lim = 32'h0000_8000; end
            default: begin m = 32'hffff_ffff; lim = 32'h8000_0000; end
        endcase
        qs = qneg ? (~q + 64'd1) : q;
        rs = it.a_neg ? (~r + 64'd1) : r;
        ovf = (q[63:32] != '0) || (qneg ? (q[31:0] > lim) : (q[31:0] >= lim));
        sp = qneg ? (~p + 64'd1) : p;
        res_next = '{div_err: 1'b0, cf: 1'b0, r_hi: it.hi, r_lo: it.lo};
        case (it.op) inside
            OP_DIV: begin
                if (it.b_mag == '0 || ovf) begin
                    res_next.div_err = 1'b1;
                end else begin
                    res_next.r_lo = qs[31:0] & m;
                    res_next.r_hi = rs[31:0] & m;
                end
            end
            OP_MULW, OP_MULT: begin
                pl = sp[31:0] & m;
                case (it.sz)
                    SZ_8:    res_next.cf = sp != {{56{sp[7]}}, sp[7:0]};
                    SZ_16:   res_next.cf = sp != {{48{sp[15]}}, sp[15:0]};
                    default: res_next.cf = sp != {{32{sp[31]}}, sp[31:0]};
                endcase
                res_next.r_lo = pl;
                if (it.op == OP_MULW) begin
                    case (it.sz)
                        SZ_8:    res_next.r_hi = {24'd0, sp[15:8]};
                        SZ_16:   res_next.r_hi = {16'd0, sp[31:16]};
                        default: res_next.r_hi = sp[63:32];
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Valid bits and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg      <= '0;
            rvalid_reg <= 1'b0;
        end else if (adv) begin
            v_reg      <= {v_reg[NS-1:0], in_valid};
            rvalid_reg <= v_reg[NS];
        end
        if (adv) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = rvalid_reg;
    assign out_res   = res_reg;

`include "signed_multiply_divide_unit_macros.svh"
    `SMDU_ASSERT_NEXT(a_hold, aclk, aresetn, rvalid_reg && !out_ready, rvalid_reg && $stable(res_reg), "result dropped while stalled")
    `SMDU_ASSERT_IMPL(a_div_cf, aclk, aresetn, rvalid_reg && res_reg.div_err, !res_reg.cf, "flags both set")
    `SMDU_ASSERT_NEXT(a_shift, aclk, aresetn, adv, v_reg[0] == $past(in_valid), "pipeline valid lost")
endmodule

>>> rtl/signed_multiply_divide_unit.sv
// Channel | Ports          | Item
// s_axis  | s_tvalid/ready | operation, size, low, high, source operands
// m_axis  | m_tvalid/ready | result_low, result_high, carry_overflow, error
//
// One item is accepted per cycle when the result side takes results.
// Items pass the front register, the queue, a 65-stage divide/multiply
// pipeline (one quotient bit per divide stage) and the result register.
// Reset is synchronous on aresetn low and empties every stage.
// A stalled result holds the back pipeline; the queue absorbs the front.
module signed_multiply_divide_unit
    import smdu_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // operation[1:0], size[3:2], low_operand[35:4], high_operand[67:36],
    // source_operand[99:68], zero fill[103:100]
    input  logic [smdu_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result_low[31:0], result_high[63:32], carry_overflow[64],
    // divide_error[65], zero fill[71:66]
    output logic [smdu_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    logic       f_valid, f_ready, b_valid, b_ready;
    smdu_item_t f_item, b_item;
    smdu_res_t  res;

    smdu_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    smdu_queue #(.DEPTH(QDEPTH)) u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
    );

    smdu_back u_back (
        .aclk, .aresetn,
        .in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {6'd0, res.div_err, res.cf, res.r_hi, res.r_lo};
endmodule
